@@ src/pccm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pccm_pkg: shared types and constants of the point cloud centroid mask
// Payload structs, opcodes, controller/datapath command and status, and the
// fixed arithmetic widths of the distance datapath.
// ----------------------------------------------------------------------------
package pccm_pkg;

   // Field widths
   localparam int COORD_BITS = 20;               // signed coordinate, mm
   localparam int RAD_W      = COORD_BITS - 1;   // stored radius, never negative
   localparam int DZ_W       = 16;               // dead zone radius register
   localparam int DZ_SQ_W    = 2 * DZ_W;

   // Point distance from the sensor: |p| <= 2^(C-1)
   localparam int PT_SQ_W    = 2 * COORD_BITS - 1;
   localparam int PT_SUM_W   = PT_SQ_W + 1;

   // Point to centroid distance: |dx| <= 2^C
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SQ_W       = 2 * COORD_BITS + 1;
   localparam int DIST_W     = SQ_W + 1;
   localparam int RSQ_W      = 2 * RAD_W;

   // Starting nearest distance: 1000 m squared, in mm^2
   localparam logic [DIST_W-1:0] INIT_MIN_SQ = DIST_W'(64'd1000000000000);

   localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(1800);
   localparam int MAX_CENTROIDS_DEF = 64;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_FILTER = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic signed [COORD_BITS-1:0] cover_radius;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
      logic                         removed;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;    // empty the centroid table
      logic append;   // append the request as a centroid
      logic load;     // capture the request as the point to filter
      logic start;    // rewind the scan index
      logic issue;    // read the entry at the scan index and advance
      logic emit;     // load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic dz_hit;   // point lies in the dead zone
      logic empty;    // centroid table is empty
      logic last;     // scan index is the last filled entry
      logic hit;      // scan found a covering centroid
      logic busy;     // scan pipeline still holds entries
   } sts_type;

endpackage
`default_nettype wire

@@ src/pccm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pccm_ram: simple dual-port RAM
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module pccm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ src/pccm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pccm_ctrl: request sequencer of the centroid mask
// Decodes opcodes, walks a filter request through the dead zone test and the
// table scan, and owns the result valid flag.
// ----------------------------------------------------------------------------
module pccm_ctrl
   import pccm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_opcode,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire sts_type    sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DECIDE,
      ST_SCAN,
      ST_DRAIN,
      ST_OUTPUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_xfer;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_opcode)
                  OP_CLEAR:  cmd.clear  = 1'b1;
                  OP_APPEND: cmd.append = 1'b1;
                  OP_FILTER: begin
                     cmd.load = 1'b1;
                     state_in = ST_SQUARE;
                  end
                  default: ;
               endcase
            end
         end
         ST_SQUARE: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (sts.dz_hit || sts.empty) begin
               state_in = ST_OUTPUT;
            end else begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // stop issuing once a covering centroid is found
            if (sts.hit) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
               if (sts.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!sts.busy) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ src/pccm_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pccm_datapath: centroid table, distance pipeline and result register
// Holds the dead zone register and fill count, squares the point for the
// dead zone test, and runs a five stage scan pipeline over the table that
// tracks the nearest centroid and flags a covering one.
// ----------------------------------------------------------------------------
module pccm_datapath
   import pccm_pkg::*;
#(
   parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_wr_en,
   input  wire logic [DZ_W-1:0] csr_wr_data,
   input  wire req_type         req_payload,
   input  wire cmd_type         cmd,
   output sts_type              sts,
   output rsp_type              rsp_payload
);

   localparam int ADDR_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
   localparam int CNT_W  = $clog2(MAX_CENTROIDS + 1);
   localparam int WORD_W = 2 * COORD_BITS + RAD_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CENTROIDS);

   // Configuration and table bookkeeping
   logic [DZ_W-1:0]  dz_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             full;
   logic             wr_en;
   logic [RAD_W-1:0] rad_clip;
   logic [WORD_W-1:0] rd_data;

   // Point under test
   logic signed [COORD_BITS-1:0] pt_x_ff, pt_y_ff, pt_z_ff;

   // Dead zone squares
   logic signed [2*COORD_BITS-1:0] px_prod, py_prod;
   logic [PT_SQ_W-1:0]  px_sq_ff, py_sq_ff;
   logic [DZ_SQ_W-1:0]  dz_sq_ff;
   logic [PT_SUM_W-1:0] pt_sum;

   // Scan pipeline
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic s1_first_ff, s2_first_ff, s3_first_ff, s4_first_ff;
   logic signed [COORD_BITS-1:0] cx, cy;
   logic [RAD_W-1:0]  cr;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic [RAD_W-1:0]  r_ff;
   logic signed [2*DIFF_W-1:0] dx_prod, dy_prod;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [RSQ_W-1:0]  rsq2_ff, rsq3_ff, rsq_in;
   logic [DIST_W-1:0] d_ff;
   logic [DIST_W-1:0] min_ff, min_in, min_ref;
   logic [RSQ_W-1:0]  best_rsq_ff, best_rsq_in;
   logic              closer;
   logic              hit_ff;
   logic              removed;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= DZ_RESET;
      end else if (csr_wr_en) begin
         dz_ff <= csr_wr_data;
      end
   end

   // Fill count: clear empties, appends to a full table are dropped
   assign full     = (count_ff == CNT_MAX);
   assign wr_en    = cmd.append && !full;
   assign rad_clip = req_payload.cover_radius[COORD_BITS-1] ? '0
                                                            : req_payload.cover_radius[RAD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.start) begin
         idx_ff <= '0;
      end else if (cmd.issue) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   pccm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_CENTROIDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_payload.coord_x, req_payload.coord_y, rad_clip}),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Point capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pt_x_ff <= req_payload.coord_x;
         pt_y_ff <= req_payload.coord_y;
         pt_z_ff <= req_payload.coord_z;
      end
   end

   // Dead zone: squares registered, sum and compare after
   assign px_prod = pt_x_ff * pt_x_ff;
   assign py_prod = pt_y_ff * pt_y_ff;

   always_ff @(posedge clock) begin
      px_sq_ff <= px_prod[PT_SQ_W-1:0];
      py_sq_ff <= py_prod[PT_SQ_W-1:0];
      dz_sq_ff <= dz_ff * dz_ff;
   end

   assign pt_sum = {1'b0, px_sq_ff} + {1'b0, py_sq_ff};

   // Scan valid and first-entry flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= (idx_ff == '0);
      s2_first_ff <= s1_first_ff;
      s3_first_ff <= s2_first_ff;
      s4_first_ff <= s3_first_ff;
   end

   // Stage 1: differences from the entry just read
   assign cx    = rd_data[WORD_W-1 -: COORD_BITS];
   assign cy    = rd_data[RAD_W +: COORD_BITS];
   assign cr    = rd_data[RAD_W-1:0];
   assign dx_in = {pt_x_ff[COORD_BITS-1], pt_x_ff} - {cx[COORD_BITS-1], cx};
   assign dy_in = {pt_y_ff[COORD_BITS-1], pt_y_ff} - {cy[COORD_BITS-1], cy};

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      r_ff  <= cr;
   end

   // Stage 2: squares
   assign dx_prod = dx_ff * dx_ff;
   assign dy_prod = dy_ff * dy_ff;
   assign rsq_in  = r_ff * r_ff;

   always_ff @(posedge clock) begin
      sqx_ff  <= dx_prod[SQ_W-1:0];
      sqy_ff  <= dy_prod[SQ_W-1:0];
      rsq2_ff <= rsq_in;
   end

   // Stage 3: squared distance
   always_ff @(posedge clock) begin
      d_ff    <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      rsq3_ff <= rsq2_ff;
   end

   // Stage 4: running nearest; the first entry is always taken as best,
   // ties keep the earlier entry
   assign min_ref = s4_first_ff ? INIT_MIN_SQ : min_ff;
   assign closer  = (min_ref > d_ff);

   always_comb begin
      min_in      = min_ff;
      best_rsq_in = best_rsq_ff;
      if (s4_vld_ff) begin
         min_in = closer ? d_ff : min_ref;
         if (closer || s4_first_ff) begin
            best_rsq_in = rsq3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      min_ff      <= min_in;
      best_rsq_ff <= best_rsq_in;
   end

   // Stage 5: cover test, sticky until the next point
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.load) begin
         hit_ff <= 1'b0;
      end else if (s5_vld_ff && ({{(DIST_W-RSQ_W){1'b0}}, best_rsq_ff} > min_ff)) begin
         hit_ff <= 1'b1;
      end
   end

   // Status
   assign sts.dz_hit = ({{(PT_SUM_W-DZ_SQ_W){1'b0}}, dz_sq_ff} > pt_sum);
   assign sts.empty  = (count_ff == '0);
   assign sts.last   = ((idx_ff + CNT_W'(1)) == count_ff);
   assign sts.hit    = hit_ff;
   assign sts.busy   = s1_vld_ff || s2_vld_ff || s3_vld_ff || s4_vld_ff || s5_vld_ff;

   // Result register
   assign removed = sts.dz_hit || hit_ff;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_payload.out_x   <= removed ? '0 : pt_x_ff;
         rsp_payload.out_y   <= removed ? '0 : pt_y_ff;
         rsp_payload.out_z   <= removed ? '0 : pt_z_ff;
         rsp_payload.removed <= removed;
      end
   end

endmodule
`default_nettype wire

@@ src/point_cloud_centroid_mask.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// point_cloud_centroid_mask: lidar point filter against a centroid table
// Request channel (req_): opcode clear, append centroid, or filter point.
// Clear and append complete in the transfer cycle and give no response.
// A filter request gives one response (rsp_): the point, or zeros with
// removed set when it falls inside the dead zone or a covering centroid.
// A filter request that the dead zone decides, or that meets an empty table,
// skips the scan; otherwise the table is scanned entry by entry, and a
// covering centroid ends the scan early. The scan reads one table entry per
// cycle through the single table read port, and a new request is taken only
// once the filter has finished and loaded its response.
// The response sits in an output register: a new request is taken while a
// stalled response waits, and a finished filter holds until rsp_ready frees
// the register.
// Reset (synchronous) empties the table, drops any pending response and sets
// the dead zone radius to 1800 mm; csr_ writes pass dz_ff, then dz_sq_ff.
// ----------------------------------------------------------------------------
module point_cloud_centroid_mask
   import pccm_pkg::*;
#(
   parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_type         req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_type              rsp_payload,
   input  wire logic            csr_wr_en,
   input  wire logic [DZ_W-1:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   pccm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   pccm_datapath #(
      .MAX_CENTROIDS (MAX_CENTROIDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

@@ src/pccm_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pccm_checker: port-level assertions for the centroid mask
// Watches the request and response channels of the top level; bound below.
// ----------------------------------------------------------------------------
module pccm_checker
   import pccm_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire req_type         req_payload,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_type         rsp_payload
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed or dropped while stalled");

   // a removed point is reported as all zeros
   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.removed |->
         rsp_payload.out_x == '0 && rsp_payload.out_y == '0 && rsp_payload.out_z == '0)
      else $error("removed point carries nonzero coordinates");

   // a filter transfer keeps the request side busy for the next cycle
   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.opcode == OP_FILTER |=> !req_ready)
      else $error("request taken while a filter is in progress");

   // reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind point_cloud_centroid_mask pccm_checker u_checker (.*);
`default_nettype wire
